// File: rtl/mets_pkg.sv
// Shared types and fixed constants of the Mandelbrot escape test unit.
package mets_pkg;

	localparam int ITER_W  = 12;
	localparam int COORD_W = 32;
	localparam int TALLY_W = 32;

	localparam logic [ITER_W-1:0]  ITER_RESET = ITER_W'(1000);
	localparam logic [TALLY_W-1:0] TALLY_MAX  = '1;

	// datapath commands from the controller
	typedef struct packed {
		logic load;
		logic mul;
		logic sum;
		logic upd;
		logic finish;
		logic outside;
	} mets_cmd_t;

	// datapath status to the controller
	typedef struct packed {
		logic escape;
	} mets_sts_t;

endpackage

// File: rtl/mets_mul.sv
// Two-stage fixed-point multiply: half-width partial products, then shift, round and saturate.
module mets_mul #(
	parameter int WORD_BITS = 32,
	parameter int SHIFT     = 28
) (
	input  logic                        clk,
	input  logic                        en1,
	input  logic                        en2,
	input  logic signed [WORD_BITS-1:0] a,
	input  logic signed [WORD_BITS-1:0] b,
	output logic signed [WORD_BITS-1:0] p
);

	localparam int W  = WORD_BITS;
	localparam int H  = (W + 1) / 2;
	localparam int PW = 4 * H;

	localparam logic [PW-1:0] WMAX  = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic [PW-1:0] WMAX1 = WMAX + PW'(1);
	localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

	logic [W-1:0]   ma, mb;
	logic [2*H-1:0] max, mbx;
	logic [2*H-1:0] ll_s1, lh_s1, hl_s1, hh_s1;
	logic           neg_s1;
	logic [PW-1:0]  prod, q, qn;
	logic           rem;
	logic signed [W-1:0] res;
	logic signed [W-1:0] p_s2;

	always_comb begin
		ma  = a[W-1] ? W'(-a) : W'(a);
		mb  = b[W-1] ? W'(-b) : W'(b);
		max = (2*H)'(ma);
		mbx = (2*H)'(mb);
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			ll_s1  <= max[H-1:0]   * mbx[H-1:0];
			lh_s1  <= max[H-1:0]   * mbx[2*H-1:H];
			hl_s1  <= max[2*H-1:H] * mbx[H-1:0];
			hh_s1  <= max[2*H-1:H] * mbx[2*H-1:H];
			neg_s1 <= a[W-1] ^ b[W-1];
		end
	end

	always_comb begin
		prod = PW'(ll_s1) + ((PW'(lh_s1) + PW'(hl_s1)) << H) + (PW'(hh_s1) << (2*H));
		q    = prod >> SHIFT;
		rem  = |prod[SHIFT-1:0];
		qn   = q + PW'(rem);
		if (!neg_s1) begin
			res = (q > WMAX) ? SMAX : q[W-1:0];
		end else begin
			res = (qn > WMAX1) ? SMIN : W'(-qn[W-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			p_s2 <= res;
		end
	end

	assign p = p_s2;

endmodule

// File: rtl/mets_dp.sv
// Datapath: point and z registers, three multiply units, update adders, escape test, tally.
module mets_dp import mets_pkg::*; #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 28
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic signed [COORD_W-1:0] c_real,
	input  logic signed [COORD_W-1:0] c_imag,
	input  logic                      restart_count,
	input  mets_cmd_t                 cmd,
	output mets_sts_t                 sts,
	output logic                      outside,
	output logic [TALLY_W-1:0]        outside_total
);

	localparam int W = WORD_BITS;
	localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [W:0]   FOUR = (W+1)'(1) << (FRAC_BITS + 2);

	logic signed [W-1:0] cr_ld, ci_ld;
	logic signed [W-1:0] cr_q, ci_q, zr_q, zi_q;
	logic signed [W-1:0] rr, ii, ri2;
	logic signed [W:0]   mag2;
	logic                restart_q;
	logic                outside_q;
	logic [TALLY_W-1:0]  tally_q, total_q, tally_nx;

	function automatic logic signed [W-1:0] sat_add(
		input logic signed [W-1:0] x,
		input logic signed [W-1:0] y
	);
		logic signed [W:0] s;
		s = {x[W-1], x} + {y[W-1], y};
		if (s[W] != s[W-1]) begin
			return s[W] ? SMIN : SMAX;
		end
		return s[W-1:0];
	endfunction

	function automatic logic signed [W-1:0] sat_sub(
		input logic signed [W-1:0] x,
		input logic signed [W-1:0] y
	);
		logic signed [W:0] s;
		s = {x[W-1], x} - {y[W-1], y};
		if (s[W] != s[W-1]) begin
			return s[W] ? SMIN : SMAX;
		end
		return s[W-1:0];
	endfunction

	generate
		if (W == COORD_W) begin : g_same
			assign cr_ld = c_real;
			assign ci_ld = c_imag;
		end else if (W > COORD_W) begin : g_wide
			assign cr_ld = W'(c_real);
			assign ci_ld = W'(c_imag);
		end else begin : g_narrow
			localparam logic signed [COORD_W-1:0] LMAX = COORD_W'((64'sd1 <<< (W-1)) - 64'sd1);
			localparam logic signed [COORD_W-1:0] LMIN = -LMAX - COORD_W'(1);
			assign cr_ld = (c_real > LMAX) ? SMAX : (c_real < LMIN) ? SMIN : c_real[W-1:0];
			assign ci_ld = (c_imag > LMAX) ? SMAX : (c_imag < LMIN) ? SMIN : c_imag[W-1:0];
		end
	endgenerate

	mets_mul #(.WORD_BITS(W), .SHIFT(FRAC_BITS)) u_mul_rr (
		.clk(clk), .en1(cmd.mul), .en2(cmd.sum), .a(zr_q), .b(zr_q), .p(rr)
	);

	mets_mul #(.WORD_BITS(W), .SHIFT(FRAC_BITS)) u_mul_ii (
		.clk(clk), .en1(cmd.mul), .en2(cmd.sum), .a(zi_q), .b(zi_q), .p(ii)
	);

	mets_mul #(.WORD_BITS(W), .SHIFT(FRAC_BITS - 1)) u_mul_ri (
		.clk(clk), .en1(cmd.mul), .en2(cmd.sum), .a(zr_q), .b(zi_q), .p(ri2)
	);

	// squares are never negative, so the unsaturated sum gives the same compare
	assign mag2       = {rr[W-1], rr} + {ii[W-1], ii};
	assign sts.escape = mag2 > FOUR;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cr_q      <= cr_ld;
			ci_q      <= ci_ld;
			zr_q      <= cr_ld;
			zi_q      <= ci_ld;
			restart_q <= restart_count;
		end else if (cmd.upd) begin
			zr_q <= sat_add(sat_sub(rr, ii), cr_q);
			zi_q <= sat_add(ri2, ci_q);
		end
	end

	always_comb begin
		tally_nx = restart_q ? '0 : tally_q;
		if (cmd.outside && tally_nx != TALLY_MAX) begin
			tally_nx = tally_nx + TALLY_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tally_q <= '0;
		end else if (cmd.finish) begin
			tally_q <= tally_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			outside_q <= cmd.outside;
			total_q   <= tally_nx;
		end
	end

	assign outside       = outside_q;
	assign outside_total = total_q;

endmodule

// File: rtl/mets_ctrl.sv
// Controller: handshakes, iteration limit register, iteration counter and sequencing FSM.
module mets_ctrl import mets_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [ITER_W-1:0] cfg_data,
	input  mets_sts_t         sts,
	output mets_cmd_t         cmd
);

	typedef enum logic [2:0] {S_IDLE, S_MUL, S_SUM, S_TEST, S_FINISH} state_t;

	state_t            state_q;
	logic [ITER_W-1:0] limit_q, iter_q;
	logic              res_q, out_valid_q;
	logic              go_esc, go_done, out_free;

	always_comb begin
		go_esc   = (iter_q != '0) && sts.escape;
		go_done  = iter_q == limit_q;
		out_free = !out_valid_q || !out_stall;
		cmd      = '0;
		cmd.outside = res_q;
		unique case (state_q)
			S_IDLE:   cmd.load   = in_valid;
			S_MUL:    cmd.mul    = 1'b1;
			S_SUM:    cmd.sum    = 1'b1;
			S_TEST:   cmd.upd    = !go_esc && !go_done;
			S_FINISH: cmd.finish = out_free;
			default:  cmd        = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			limit_q     <= ITER_RESET;
			iter_q      <= '0;
			res_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				limit_q <= cfg_data;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						iter_q  <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_SUM;
				S_SUM: state_q <= S_TEST;
				S_TEST: begin
					if (go_esc) begin
						res_q   <= 1'b1;
						state_q <= S_FINISH;
					end else if (go_done) begin
						res_q   <= 1'b0;
						state_q <= S_FINISH;
					end else begin
						iter_q  <= iter_q + ITER_W'(1);
						state_q <= S_MUL;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;
	assign cfg_ready = 1'b1;

endmodule

// File: rtl/mandelbrot_escape_test_unit.sv
// Top level of the Mandelbrot escape test unit.
// One point is worked at a time. Each pass through the multiply, sum and test states
// either updates z = z*z + c or ends the point, on escape or at max_iterations
// updates; the point then posts its result and frees the input. The post waits as
// long as an earlier result is still stalled by the receiver. The result register
// lets the next point start while a result still waits to be taken.
module mandelbrot_escape_test_unit import mets_pkg::*; #(
	parameter int FRAC_BITS = 28,
	parameter int WORD_BITS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [COORD_W-1:0] c_real,
	input  logic signed [COORD_W-1:0] c_imag,
	input  logic                      restart_count,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      outside,
	output logic [TALLY_W-1:0]        outside_total,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [ITER_W-1:0]         cfg_data
);

	mets_cmd_t cmd;
	mets_sts_t sts;

	mets_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.sts       (sts),
		.cmd       (cmd)
	);

	mets_dp #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.c_real        (c_real),
		.c_imag        (c_imag),
		.restart_count (restart_count),
		.cmd           (cmd),
		.sts           (sts),
		.outside       (outside),
		.outside_total (outside_total)
	);

endmodule

// File: rtl/mets_checker.sv
// Port-level assertions for the Mandelbrot escape test unit, bound to the top level.
module mets_checker import mets_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic               outside,
	input logic [TALLY_W-1:0] outside_total
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(outside) && $stable(outside_total))
		else $error("stalled result changed");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall ##1 in_stall ##1 in_stall ##1 in_stall)
		else $error("input freed before one loop pass and result post");

	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without an item in work");

	a_tally_counts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && outside |-> outside_total != '0)
		else $error("outside item not counted");

endmodule

bind mandelbrot_escape_test_unit mets_checker u_chk (.*);

// File: bench/escape_checker.sv
// Checker for the Mandelbrot escape test unit: watches the channels, predicts and compares.
`timescale 1ns / 100ps
module escape_checker import mets_pkg::*; #(
	parameter int FRAC_BITS = 28,
	parameter int WORD_BITS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic signed [COORD_W-1:0] c_real,
	input  logic signed [COORD_W-1:0] c_imag,
	input  logic                      restart_count,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic                      outside,
	input  logic [TALLY_W-1:0]        outside_total,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [ITER_W-1:0]         cfg_data,
	output int                        results_due,
	output int                        escaped_points,
	output int                        mismatches
);

	localparam longint WORD_MAX = (longint'(1) <<< (WORD_BITS - 1)) - 1;
	localparam longint WORD_MIN = -WORD_MAX - 1;
	localparam longint FOUR     = longint'(4) <<< FRAC_BITS;

	typedef struct {
		logic               outside;
		logic [TALLY_W-1:0] total;
	} escape_result_t;

	escape_result_t     due_q[$];
	escape_result_t     due;
	logic [ITER_W-1:0]  iter_limit;
	logic [TALLY_W-1:0] tally;
	logic               hit;

	function automatic longint word_clip(longint v);
		if (v > WORD_MAX)
			return WORD_MAX;
		if (v < WORD_MIN)
			return WORD_MIN;
		return v;
	endfunction

	// exact product, floor shift, then saturate
	function automatic longint scaled_product(longint a, longint b, int s);
		return word_clip((a * b) >>> s);
	endfunction

	function automatic longint load_coord(logic signed [COORD_W-1:0] raw);
		return word_clip(longint'(raw));
	endfunction

	function automatic logic point_escapes(longint cr, longint ci, logic [ITER_W-1:0] limit);
		longint zr;
		longint zi;
		longint nr;
		longint ni;
		int     k;
		logic   esc;
		zr = cr;
		zi = ci;
		esc = 1'b0;
		for (k = 0; k < limit && !esc; k++) begin
			nr = word_clip(word_clip(scaled_product(zr, zr, FRAC_BITS)
				- scaled_product(zi, zi, FRAC_BITS)) + cr);
			ni = word_clip(scaled_product(zr, zi, FRAC_BITS - 1) + ci);
			zr = nr;
			zi = ni;
			esc = word_clip(scaled_product(zr, zr, FRAC_BITS)
				+ scaled_product(zi, zi, FRAC_BITS)) > FOUR;
		end
		return esc;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_limit = ITER_RESET;
			tally = '0;
			due_q.delete();
			escaped_points = 0;
			mismatches = 0;
			results_due <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (due_q.size() == 0) begin
					$error("unexpected result: outside %0d, outside_total %0d",
						outside, outside_total);
					mismatches++;
				end else begin
					due = due_q.pop_front();
					if (outside !== due.outside) begin
						$error("outside: expected %0d, got %0d", due.outside, outside);
						mismatches++;
					end
					if (outside_total !== due.total) begin
						$error("outside_total: expected %0d, got %0d",
							due.total, outside_total);
						mismatches++;
					end
					if (due.outside)
						escaped_points++;
				end
			end
			if (in_valid && !in_stall) begin
				hit = point_escapes(load_coord(c_real), load_coord(c_imag), iter_limit);
				if (restart_count)
					tally = '0;
				if (hit && tally != TALLY_MAX)
					tally = tally + 1'b1;
				due.outside = hit;
				due.total = tally;
				due_q.push_back(due);
			end
			if (cfg_valid && cfg_ready)
				iter_limit = cfg_data;
			results_due <= due_q.size();
		end
	end

endmodule

// File: bench/mandelbrot_escape_test_unit_tb.sv
// Testbench top for the Mandelbrot escape test unit: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module mandelbrot_escape_test_unit_tb;
	import mets_pkg::*;

	localparam int QUIET_LIMIT = 40000;
	localparam int HOLD_CYCLES = 600;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic signed [COORD_W-1:0] c_real;
	logic signed [COORD_W-1:0] c_imag;
	logic                      restart_count;
	logic                      out_valid;
	logic                      out_stall;
	logic                      outside;
	logic [TALLY_W-1:0]        outside_total;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [ITER_W-1:0]         cfg_data;

	int   results_due;
	int   escaped_points;
	int   mismatches;
	int   send_pct;
	int   recv_pct;
	logic hold_req;
	int   points_sent;
	int   limits_used;
	int   quiet;

	mandelbrot_escape_test_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.c_real       (c_real),
		.c_imag       (c_imag),
		.restart_count(restart_count),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.outside      (outside),
		.outside_total(outside_total),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	escape_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.c_real        (c_real),
		.c_imag        (c_imag),
		.restart_count (restart_count),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.outside       (outside),
		.outside_total (outside_total),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.results_due   (results_due),
		.escaped_points(escaped_points),
		.mismatches    (mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side: random stall, or one long hold-off per request
	initial begin
		logic held;
		held = 1'b0;
		out_stall = 1'b0;
		@(posedge clk);
		forever begin
			if (hold_req && !held) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (!hold_req)
					held = 1'b0;
				out_stall <= ($urandom_range(0, 99) < recv_pct);
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			quiet <= 0;
		end else begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic send_point(logic signed [COORD_W-1:0] cr, logic signed [COORD_W-1:0] ci,
			logic rs);
		while ($urandom_range(0, 99) < send_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		c_real <= cr;
		c_imag <= ci;
		restart_count <= rs;
		do @(posedge clk); while (in_stall);
		points_sent++;
	endtask

	// mostly points near the set, the rest over the whole word
	task automatic send_random(int n);
		logic signed [COORD_W-1:0] cr;
		logic signed [COORD_W-1:0] ci;
		repeat (n) begin
			if ($urandom_range(0, 9) < 7) begin
				cr = $urandom_range(0, 32'h3000_0000);
				cr = cr - 32'h2200_0000;
				ci = $urandom_range(0, 32'h2A00_0000);
				ci = ci - 32'h1500_0000;
			end else begin
				cr = $urandom();
				ci = $urandom();
			end
			send_point(cr, ci, $urandom_range(0, 9) == 0);
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (results_due != 0);
	endtask

	task automatic write_limit(logic [ITER_W-1:0] v);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		limits_used++;
	endtask

	task automatic set_idling(int sp, int rp);
		send_pct <= sp;
		recv_pct <= rp;
	endtask

	initial begin
		in_valid = 1'b0;
		c_real = '0;
		c_imag = '0;
		restart_count = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		hold_req = 1'b0;
		send_pct = 0;
		recv_pct = 0;
		points_sent = 0;
		limits_used = 0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset limit, field extremes and known points
		send_point(32'h0000_0000, 32'h0000_0000, 1'b1);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
		send_point(32'h8000_0000, 32'h8000_0000, 1'b0);
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		send_point(32'h8000_0000, 32'h0000_0000, 1'b0);
		send_point(32'h0000_0000, 32'h7FFF_FFFF, 1'b0);
		send_point(32'hE000_0000, 32'h0000_0000, 1'b0);
		send_point(32'h0400_0000, 32'h0000_0000, 1'b0);
		send_point(32'hF400_0000, 32'h0199_999A, 1'b0);
		send_point(32'h0800_0000, 32'h0000_0000, 1'b1);
		send_point(32'hF000_0000, 32'h0000_0000, 1'b0);
		send_point(32'h0000_0000, 32'h1000_0000, 1'b0);
		send_point(32'h1000_0000, 32'h1000_0000, 1'b0);
		send_point(32'hFE66_6666, 32'h0A6A_7EF9, 1'b0);
		send_point(32'h1FFF_FFFF, 32'h0000_0000, 1'b1);
		send_point(32'h2000_0000, 32'h0000_0000, 1'b0);

		// zero limit: no update, never outside
		write_limit('0);
		set_idling(12, 12);
		send_random(8);

		write_limit(ITER_W'(1));
		set_idling(85, 0);
		send_random(40);

		write_limit('1);
		set_idling(0, 85);
		send_point(32'h0000_0000, 32'h0000_0000, 1'b0);
		send_point(32'hF000_0000, 32'h0000_0000, 1'b0);
		send_point(32'h0400_0000, 32'h0000_0000, 1'b0);
		send_random(5);

		write_limit(ITER_W'($urandom_range(2, 48)));
		set_idling(0, 0);
		send_random(125);
		write_limit(ITER_W'($urandom_range(2, 48)));
		set_idling(85, 0);
		send_random(125);
		write_limit(ITER_W'($urandom_range(2, 48)));
		set_idling(0, 85);
		send_random(125);
		write_limit(ITER_W'($urandom_range(2, 48)));
		set_idling(12, 12);
		send_random(125);

		// long receiver hold-off while points keep coming
		write_limit(ITER_W'(20));
		set_idling(0, 0);
		hold_req <= 1'b1;
		send_random(40);
		hold_req <= 1'b0;

		settle();
		repeat (200) @(posedge clk);
		$display("Sent %0d points under %0d iteration limits (0, 1, 4095, reset and random).",
			points_sent, limits_used);
		$display("%0d escaped; gaps, stalls and a %0d-cycle result hold-off were applied.",
			escaped_points, HOLD_CYCLES);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
